// ===== design/jpit_pkg.sv =====
// Shared types and constants for the joint PD impedance torque block.
package jpit_pkg;

   localparam int unsigned QW    = 32;  // Q16.16 word
   localparam int unsigned ERRW  = 33;  // exact difference of two Q16.16 words
   localparam int unsigned GAINW = 31;  // unsigned gain and limit registers
   localparam int unsigned ALPW  = 16;  // filter weight, Q1.15
   localparam int unsigned PRODW = ERRW + QW;  // shared multiplier product
   localparam int unsigned ACCW  = PRODW + 1;  // accumulator

   localparam logic [ALPW-1:0] ALPHA_BYPASS = 16'd32765;
   localparam logic [ALPW:0]   ALPHA_ONE    = 17'd32768;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_DERIV_GAIN     = 3'd1,
      CSR_EFFORT_LIMIT   = 3'd2,
      CSR_LIMIT_ENABLE   = 3'd3,
      CSR_GRAVITY_ENABLE = 3'd4,
      CSR_FILTER_ALPHA   = 3'd5,
      CSR_REF_VEL_LIMIT  = 3'd6,
      CSR_CHAINED_MODE   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_A,
      ST_FILT_B,
      ST_FILT_C,
      ST_PREP,
      ST_PMUL,
      ST_DMUL,
      ST_ACC_D,
      ST_ACC_FF,
      ST_SAT,
      ST_LIM,
      ST_OUT
   } state_type;

   // Operand pairs presented to the shared multiplier.
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_ALPHA_VEL,
      MUL_BETA_FILT,
      MUL_KP_ERR,
      MUL_KD_ERR
   } mul_sel_type;

   typedef struct packed {
      logic        ready;
      mul_sel_type mul_sel;
   } ctrl_type;

endpackage

// ===== design/joint_pd_impedance_torque.sv =====
// Joint PD impedance torque controller: one control sample in, one torque command out.
// One beat on the request channel is one control sample of a single joint; the block
// answers it with exactly one response beat carrying the saturated, optionally clamped
// torque command and a flag that tells whether saturation or the effort clamp changed it.
// Every product runs through a single 33x32 signed multiplier under a small sequencer;
// when the low-pass velocity filter is active, the sequencer steps through FILT_A,
// FILT_B and FILT_C for the filter's two products before PREP, and when the filter is
// bypassed or being primed it goes from idle straight to PREP. After the output state
// the sequencer returns to idle before it can take the next sample, and a
// response that the consumer has not yet taken holds the sequencer in its last state.
// The request side is ready only while the sequencer is idle; the response sits in its
// own register, so the next sample can be accepted while the previous result still waits
// for the consumer. Configuration writes are taken in any cycle but must only be issued
// while no sample is in flight. The first sample after reset loads the velocity filter
// directly.
module joint_pd_impedance_torque (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // meas_pos[31:0], meas_vel[63:32], ref_pos[95:64], ref_vel[127:96],
   // torque_ff[159:128], gravity_torque[191:160]
   input  logic [191:0] req_tdata,
   // ref_pos_valid[0], ref_vel_valid[1]
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // torque_cmd[31:0]
   output logic [31:0]  rsp_tdata,
   // was_clamped[0]
   output logic         rsp_tuser,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int unsigned QW    = jpit_pkg::QW;
   localparam int unsigned ERRW  = jpit_pkg::ERRW;
   localparam int unsigned GAINW = jpit_pkg::GAINW;
   localparam int unsigned ALPW  = jpit_pkg::ALPW;
   localparam int unsigned PRODW = jpit_pkg::PRODW;
   localparam int unsigned ACCW  = jpit_pkg::ACCW;

   localparam logic signed [ACCW-1:0] ACC_MAX = {{(ACCW-QW+1){1'b0}}, {(QW-1){1'b1}}};
   localparam logic signed [ACCW-1:0] ACC_MIN = {{(ACCW-QW+1){1'b1}}, {(QW-1){1'b0}}};

   // Configuration registers.
   logic [GAINW-1:0] prop_gain_ff, deriv_gain_ff, effort_limit_ff, ref_vel_limit_ff;
   logic             limit_enable_ff, gravity_enable_ff, chained_mode_ff;
   logic [ALPW-1:0]  filter_alpha_ff;

   // Sequencer and filter state.
   jpit_pkg::state_type state_ff, state_in;
   jpit_pkg::ctrl_type  ctrl;
   logic                primed_ff;
   logic signed [QW-1:0] filt_vel_ff;

   // Captured sample and working registers.
   logic signed [QW-1:0]   mpos_ff, mvel_ff, rpos_ff, rvel_ff, ff_ff, grav_ff;
   logic signed [QW-1:0]   rvel_clip_ff;
   logic signed [ERRW-1:0] perr_ff, verr_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic signed [QW-1:0]   tau_ff;
   logic                   clamped_ff;

   // Response register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic req_fire, rsp_free, bypass;

   // Multiplier operands and product.
   logic signed [ERRW-1:0]  mul_a;
   logic signed [QW-1:0]    mul_b;
   logic signed [PRODW-1:0] prod;
   logic [ALPW-1:0]         beta;

   // Combinational helpers.
   logic signed [PRODW-1:0] rnd_sum;
   logic signed [ACCW-1:0]  rnd_ext, prod_ext, filt_sum;
   logic signed [ERRW-1:0]  rvel_wide, vlim_pos, vlim_neg;
   logic signed [ERRW-1:0]  tau_wide, elim_pos, elim_neg;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign bypass     = !primed_ff || (filter_alpha_ff >= jpit_pkg::ALPHA_BYPASS);
   assign csr_ready  = 1'b1;
   assign req_tready = ctrl.ready;

   // Configuration writes; each value is masked to its register width.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= '0;
         deriv_gain_ff     <= '0;
         effort_limit_ff   <= '1;
         limit_enable_ff   <= 1'b0;
         gravity_enable_ff <= 1'b1;
         filter_alpha_ff   <= ALPW'(jpit_pkg::ALPHA_ONE);
         ref_vel_limit_ff  <= GAINW'(131072);
         chained_mode_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (jpit_pkg::csr_index_type'(csr_index))
            jpit_pkg::CSR_PROP_GAIN:      prop_gain_ff      <= csr_data[GAINW-1:0];
            jpit_pkg::CSR_DERIV_GAIN:     deriv_gain_ff     <= csr_data[GAINW-1:0];
            jpit_pkg::CSR_EFFORT_LIMIT:   effort_limit_ff   <= csr_data[GAINW-1:0];
            jpit_pkg::CSR_LIMIT_ENABLE:   limit_enable_ff   <= csr_data[0];
            jpit_pkg::CSR_GRAVITY_ENABLE: gravity_enable_ff <= csr_data[0];
            jpit_pkg::CSR_FILTER_ALPHA:   filter_alpha_ff   <= csr_data[ALPW-1:0];
            jpit_pkg::CSR_REF_VEL_LIMIT:  ref_vel_limit_ff  <= csr_data[GAINW-1:0];
            jpit_pkg::CSR_CHAINED_MODE:   chained_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jpit_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = bypass ? jpit_pkg::ST_PREP : jpit_pkg::ST_FILT_A;
            end
         end
         jpit_pkg::ST_FILT_A: state_in = jpit_pkg::ST_FILT_B;
         jpit_pkg::ST_FILT_B: state_in = jpit_pkg::ST_FILT_C;
         jpit_pkg::ST_FILT_C: state_in = jpit_pkg::ST_PREP;
         jpit_pkg::ST_PREP:   state_in = jpit_pkg::ST_PMUL;
         jpit_pkg::ST_PMUL:   state_in = jpit_pkg::ST_DMUL;
         jpit_pkg::ST_DMUL:   state_in = jpit_pkg::ST_ACC_D;
         jpit_pkg::ST_ACC_D:  state_in = jpit_pkg::ST_ACC_FF;
         jpit_pkg::ST_ACC_FF: state_in = jpit_pkg::ST_SAT;
         jpit_pkg::ST_SAT:    state_in = jpit_pkg::ST_LIM;
         jpit_pkg::ST_LIM:    state_in = jpit_pkg::ST_OUT;
         jpit_pkg::ST_OUT: begin
            if (rsp_free) begin
               state_in = jpit_pkg::ST_IDLE;
            end
         end
         default: state_in = jpit_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand choice.
   always_comb begin
      ctrl.ready   = 1'b0;
      ctrl.mul_sel = jpit_pkg::MUL_NONE;
      case (state_ff)
         jpit_pkg::ST_IDLE:   ctrl.ready   = 1'b1;
         jpit_pkg::ST_FILT_A: ctrl.mul_sel = jpit_pkg::MUL_ALPHA_VEL;
         jpit_pkg::ST_FILT_B: ctrl.mul_sel = jpit_pkg::MUL_BETA_FILT;
         jpit_pkg::ST_PMUL:   ctrl.mul_sel = jpit_pkg::MUL_KP_ERR;
         jpit_pkg::ST_DMUL:   ctrl.mul_sel = jpit_pkg::MUL_KD_ERR;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jpit_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand selection for the shared multiplier.
   assign beta = ALPW'(jpit_pkg::ALPHA_ONE - {1'b0, filter_alpha_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_sel)
         jpit_pkg::MUL_ALPHA_VEL: begin
            mul_a = ERRW'(mvel_ff);
            mul_b = {{(QW-ALPW){1'b0}}, filter_alpha_ff};
         end
         jpit_pkg::MUL_BETA_FILT: begin
            mul_a = ERRW'(filt_vel_ff);
            mul_b = {{(QW-ALPW){1'b0}}, beta};
         end
         jpit_pkg::MUL_KP_ERR: begin
            mul_a = perr_ff;
            mul_b = {1'b0, prop_gain_ff};
         end
         jpit_pkg::MUL_KD_ERR: begin
            mul_a = verr_ff;
            mul_b = {1'b0, deriv_gain_ff};
         end
         default: ;
      endcase
   end

   jpit_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Rounding of a gain product to Q16.16, the filter sum, and the clamp bounds.
   always_comb begin
      rnd_sum   = prod + PRODW'(32768);
      rnd_ext   = {{(ACCW-PRODW+16){rnd_sum[PRODW-1]}}, rnd_sum[PRODW-1:16]};
      prod_ext  = ACCW'(prod);
      filt_sum  = acc_ff + prod_ext;
      rvel_wide = ERRW'(rvel_ff);
      vlim_pos  = {2'b00, ref_vel_limit_ff};
      vlim_neg  = -vlim_pos;
      tau_wide  = ERRW'(tau_ff);
      elim_pos  = {2'b00, effort_limit_ff};
      elim_neg  = -elim_pos;
   end

   // Datapath registers, stepped by the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff   <= 1'b0;
         filt_vel_ff <= '0;
      end else begin
         if (req_fire && bypass) begin
            // Filter is loaded directly on the first sample or when bypassed.
            filt_vel_ff <= req_tdata[63:32];
            primed_ff   <= 1'b1;
         end else if (state_ff == jpit_pkg::ST_FILT_C) begin
            filt_vel_ff <= filt_sum[QW+14:15];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mpos_ff <= req_tdata[31:0];
         mvel_ff <= req_tdata[63:32];
         rpos_ff <= req_tuser[0] ? req_tdata[95:64] : req_tdata[31:0];
         rvel_ff <= req_tuser[1] ? req_tdata[127:96] : '0;
         ff_ff   <= req_tdata[159:128];
         grav_ff <= req_tdata[191:160];
      end
      case (state_ff)
         jpit_pkg::ST_FILT_B: begin
            acc_ff <= prod_ext + ACCW'(16384);
         end
         jpit_pkg::ST_PREP: begin
            perr_ff <= ERRW'(rpos_ff) - ERRW'(mpos_ff);
            if (chained_mode_ff && (rvel_wide > vlim_pos)) begin
               rvel_clip_ff <= QW'(vlim_pos);
            end else if (chained_mode_ff && (rvel_wide < vlim_neg)) begin
               rvel_clip_ff <= QW'(vlim_neg);
            end else begin
               rvel_clip_ff <= rvel_ff;
            end
         end
         jpit_pkg::ST_PMUL: begin
            verr_ff <= ERRW'(rvel_clip_ff) - ERRW'(filt_vel_ff);
         end
         jpit_pkg::ST_DMUL: begin
            acc_ff <= rnd_ext;
         end
         jpit_pkg::ST_ACC_D: begin
            acc_ff <= acc_ff + rnd_ext;
         end
         jpit_pkg::ST_ACC_FF: begin
            // Feedforward drops out in chained mode; gravity only when enabled.
            acc_ff <= acc_ff
                    + (chained_mode_ff ? '0 : ACCW'(ff_ff))
                    + (gravity_enable_ff ? ACCW'(grav_ff) : '0);
         end
         jpit_pkg::ST_SAT: begin
            if (acc_ff > ACC_MAX) begin
               tau_ff     <= QW'(ACC_MAX);
               clamped_ff <= 1'b1;
            end else if (acc_ff < ACC_MIN) begin
               tau_ff     <= QW'(ACC_MIN);
               clamped_ff <= 1'b1;
            end else begin
               tau_ff     <= acc_ff[QW-1:0];
               clamped_ff <= 1'b0;
            end
         end
         jpit_pkg::ST_LIM: begin
            if (limit_enable_ff && (tau_wide > elim_pos)) begin
               tau_ff     <= QW'(elim_pos);
               clamped_ff <= 1'b1;
            end else if (limit_enable_ff && (tau_wide < elim_neg)) begin
               tau_ff     <= QW'(elim_neg);
               clamped_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Response register: loaded once the previous beat has left.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == jpit_pkg::ST_OUT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == jpit_pkg::ST_OUT) && rsp_free) begin
         rsp_data_ff <= tau_ff;
         rsp_user_ff <= clamped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A delivered command never exceeds the effort limit while clamping is enabled.
   logic signed [ERRW-1:0] rsp_wide;
   assign rsp_wide = ERRW'($signed(rsp_data_ff));

   a_effort_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && limit_enable_ff) |-> ((rsp_wide <= elim_pos) && (rsp_wide >= elim_neg)))
      else $error("response torque outside the effort limit");

   // Once a sample is taken, the block stays busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted again while a sample is in work");

   // The filter stays primed until the next reset.
   a_primed_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(reset) || !$fell(primed_ff))
      else $error("velocity filter lost its primed state without reset");

endmodule

// ===== design/jpit_mul.sv =====
// Shared registered signed multiplier used by every product of the torque law.
module jpit_mul (
   input  logic                                clock,
   input  logic signed [jpit_pkg::ERRW-1:0]    op_a,
   input  logic signed [jpit_pkg::QW-1:0]      op_b,
   output logic signed [jpit_pkg::PRODW-1:0]   prod
);

   logic signed [jpit_pkg::PRODW-1:0] prod_ff;
   logic signed [jpit_pkg::PRODW-1:0] prod_in;

   always_comb begin
      prod_in = jpit_pkg::PRODW'(op_a) * jpit_pkg::PRODW'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
